// ----- hdl/cts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

    // Field widths of the stream items.
    localparam int SSE_W   = 40;
    localparam int WORD_W  = 32;
    localparam int DOF_W   = 12;
    localparam int T_W     = 27;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;

    // Default fraction width of the fixed-point values.
    localparam int FRACTION_BITS_DEF = 16;

    // Clamp magnitude of the t-statistic, in whole units.
    localparam int T_LIMIT = 1000;
    // Integer bits above the fraction that hold the clamp magnitude.
    localparam int T_LIMIT_BITS = 10;

endpackage : cts_pkg

`default_nettype wire

// ----- hdl/coefficient_t_statistic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle; the pipeline of bit-serial division,
// square root and t division stages advances whenever the output register is free.
// Reset: rst_n is asynchronous, active low; it clears all valid bits and sets
// error_dof to 1. Payload registers are not reset.

module coefficient_t_statistic
    import cts_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration: error_dof.
    input  wire logic                 cfg_we,
    input  wire logic [DOF_W-1:0]     cfg_wdata,
    // Input stream. tdata from bit 0: error_sum_squares[39:0],
    // inverse_diagonal[31:0], coefficient[31:0].
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // Output stream. tdata from bit 0: std_deviation[31:0], t_statistic[26:0],
    // five zero bits.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int QB = FRACTION_BITS + T_LIMIT_BITS;
    localparam int TW = QB + T_W;
    localparam int DN = SSE_W;
    localparam int SN = WORD_W;
    localparam logic [QB-1:0] T_CLAMP = QB'(T_LIMIT) << FRACTION_BITS;

    // Configuration register.
    logic [DOF_W-1:0] error_dof_reg;
    logic [DOF_W-1:0] dof;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_dof_reg <= DOF_W'(1);
        end
        else if (cfg_we)
        begin
            error_dof_reg <= cfg_wdata;
        end
    end

    // A divisor of zero is treated as one.
    assign dof = (error_dof_reg == '0) ? DOF_W'(1) : error_dof_reg;

    // The whole pipeline moves when the output register can take a result.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Division sse / dof, one quotient bit per stage.
    logic              d_vld_reg  [0:DN];
    logic [SSE_W-1:0]  d_num_reg  [0:DN];
    logic [DOF_W-1:0]  d_rem_reg  [0:DN];
    logic [WORD_W-1:0] d_diag_reg [0:DN];
    logic [WORD_W-1:0] d_coef_reg [0:DN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_num_reg[0]  <= s_tdata[SSE_W-1:0];
            d_rem_reg[0]  <= '0;
            d_diag_reg[0] <= s_tdata[SSE_W+WORD_W-1:SSE_W];
            d_coef_reg[0] <= s_tdata[SSE_W+2*WORD_W-1:SSE_W+WORD_W];
        end
    end

    for (genvar k = 0; k < DN; k++)
    begin : g_dstage
        logic [DOF_W:0] trial;
        logic           qbit;

        always_comb
        begin
            trial = {d_rem_reg[k], d_num_reg[k][SSE_W-1]};
            qbit  = (trial >= {1'b0, dof});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                d_vld_reg[k+1] <= d_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_rem_reg[k+1]  <= qbit ? DOF_W'(trial - {1'b0, dof}) : DOF_W'(trial);
                d_num_reg[k+1]  <= {d_num_reg[k][SSE_W-2:0], qbit};
                d_diag_reg[k+1] <= d_diag_reg[k];
                d_coef_reg[k+1] <= d_coef_reg[k];
            end
        end
    end

    // Variance product mse * diag, split into two partial products.
    logic              m1_vld_reg, m2_vld_reg;
    logic              m1_pos_reg, m2_pos_reg;
    logic [50:0]       m1_lo_reg, m1_hi_reg;
    logic [WORD_W-1:0] m1_coef_reg, m2_coef_reg;
    logic [70:0]       m_prod;
    logic [63:0]       m2_prod_reg;
    logic              m2_sat_reg;
    logic [30:0]       diag_mag;

    assign diag_mag = d_diag_reg[DN][30:0];
    assign m_prod   = 71'(m1_lo_reg) + (71'(m1_hi_reg) << 20);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg <= d_vld_reg[DN];
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_lo_reg   <= d_num_reg[DN][19:0] * diag_mag;
            m1_hi_reg   <= d_num_reg[DN][39:20] * diag_mag;
            m1_pos_reg  <= !d_diag_reg[DN][31] && (d_diag_reg[DN] != '0)
                           && (d_num_reg[DN] != '0);
            m1_coef_reg <= d_coef_reg[DN];
            m2_prod_reg <= m_prod[63:0];
            m2_sat_reg  <= (m_prod[70:64] != '0);
            m2_pos_reg  <= m1_pos_reg;
            m2_coef_reg <= m1_coef_reg;
        end
    end

    // Square root of the variance, one root bit per stage.
    logic              s_vld_reg  [0:SN];
    logic [63:0]       s_rad_reg  [0:SN];
    logic [32:0]       s_rem_reg  [0:SN];
    logic [WORD_W-1:0] s_root_reg [0:SN];
    logic              s_pos_reg  [0:SN];
    logic              s_sat_reg  [0:SN];
    logic [WORD_W-1:0] s_coef_reg [0:SN];

    always_comb
    begin
        s_vld_reg[0]  = m2_vld_reg;
        s_rad_reg[0]  = m2_prod_reg;
        s_rem_reg[0]  = '0;
        s_root_reg[0] = '0;
        s_pos_reg[0]  = m2_pos_reg;
        s_sat_reg[0]  = m2_sat_reg;
        s_coef_reg[0] = m2_coef_reg;
    end

    for (genvar j = 0; j < SN; j++)
    begin : g_sstage
        logic [34:0] acc;
        logic [34:0] trial;
        logic        rbit;

        always_comb
        begin
            acc   = {s_rem_reg[j], s_rad_reg[j][63:62]};
            trial = {1'b0, s_root_reg[j], 2'b01};
            rbit  = (acc >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_vld_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                s_vld_reg[j+1] <= s_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_rem_reg[j+1]  <= rbit ? 33'(acc - trial) : 33'(acc);
                s_root_reg[j+1] <= {s_root_reg[j][WORD_W-2:0], rbit};
                s_rad_reg[j+1]  <= {s_rad_reg[j][61:0], 2'b00};
                s_pos_reg[j+1]  <= s_pos_reg[j];
                s_sat_reg[j+1]  <= s_sat_reg[j];
                s_coef_reg[j+1] <= s_coef_reg[j];
            end
        end
    end

    // Standard deviation, magnitude of the coefficient and clamp bound.
    logic              t1_vld_reg;
    logic [WORD_W-1:0] t1_sd_reg, t1_mag_reg;
    logic [41:0]       t1_lim_reg;
    logic              t1_neg_reg;
    logic [WORD_W-1:0] sd_val;
    logic [WORD_W-1:0] coef_mag;

    always_comb
    begin
        if (!s_pos_reg[SN])
        begin
            sd_val = '0;
        end
        else if (s_sat_reg[SN])
        begin
            sd_val = '1;
        end
        else
        begin
            sd_val = s_root_reg[SN];
        end
        coef_mag = s_coef_reg[SN][WORD_W-1] ? (~s_coef_reg[SN] + WORD_W'(1)) : s_coef_reg[SN];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_vld_reg <= s_vld_reg[SN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_sd_reg  <= sd_val;
            t1_mag_reg <= coef_mag;
            t1_neg_reg <= s_coef_reg[SN][WORD_W-1];
            t1_lim_reg <= sd_val * 10'(T_LIMIT);
        end
    end

    // t division (mag << FRACTION_BITS) / sd, one quotient bit per stage.
    logic              q_vld_reg   [0:QB];
    logic [WORD_W-1:0] q_rem_reg   [0:QB];
    logic [QB-1:0]     q_num_reg   [0:QB];
    logic [WORD_W-1:0] q_sd_reg    [0:QB];
    logic              q_neg_reg   [0:QB];
    logic              q_clamp_reg [0:QB];
    logic              q_zero_reg  [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            q_vld_reg[0] <= t1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_rem_reg[0]   <= WORD_W'(t1_mag_reg >> T_LIMIT_BITS);
            q_num_reg[0]   <= QB'(t1_mag_reg[T_LIMIT_BITS-1:0]) << FRACTION_BITS;
            q_sd_reg[0]    <= t1_sd_reg;
            q_neg_reg[0]   <= t1_neg_reg;
            q_clamp_reg[0] <= (42'(t1_mag_reg) > t1_lim_reg);
            q_zero_reg[0]  <= (t1_sd_reg == '0);
        end
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_qstage
        logic [WORD_W:0] trial;
        logic            qbit;

        always_comb
        begin
            trial = {q_rem_reg[i], q_num_reg[i][QB-1]};
            qbit  = (trial >= {1'b0, q_sd_reg[i]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q_vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                q_vld_reg[i+1] <= q_vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_rem_reg[i+1]   <= qbit ? WORD_W'(trial - {1'b0, q_sd_reg[i]})
                                         : WORD_W'(trial);
                q_num_reg[i+1]   <= {q_num_reg[i][QB-2:0], qbit};
                q_sd_reg[i+1]    <= q_sd_reg[i];
                q_neg_reg[i+1]   <= q_neg_reg[i];
                q_clamp_reg[i+1] <= q_clamp_reg[i];
                q_zero_reg[i+1]  <= q_zero_reg[i];
            end
        end
    end

    // Final selection, sign and output register.
    logic [QB-1:0]     tmag;
    logic [TW-1:0]     t_full;
    logic              out_vld_reg;
    logic [WORD_W-1:0] out_sd_reg;
    logic [T_W-1:0]    out_t_reg;

    always_comb
    begin
        priority if (q_clamp_reg[QB])
        begin
            tmag = T_CLAMP;
        end
        else if (q_zero_reg[QB])
        begin
            tmag = '0;
        end
        else
        begin
            tmag = q_num_reg[QB];
        end
        t_full = q_neg_reg[QB] ? (TW'(0) - TW'(tmag)) : TW'(tmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= q_vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_sd_reg <= q_sd_reg[QB];
            out_t_reg  <= t_full[T_W-1:0];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(M_TDATA_W-WORD_W-T_W)'(0), out_t_reg, out_sd_reg};

endmodule : coefficient_t_statistic

`default_nettype wire

// ----- test/tstat_checker.sv -----
`timescale 1ns / 1ps

module tstat_checker
    import cts_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [DOF_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending_count
);

    typedef struct packed {
        logic [T_W-1:0]    t_stat;
        logic [WORD_W-1:0] std_dev;
    } tstat_result_t;

    tstat_result_t  expected_results[$];
    logic [DOF_W-1:0] dof_copy;

    // Bit-by-bit integer square root of a 64-bit value.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Computes deviation and t-statistic of one coefficient.
    function automatic tstat_result_t compute_tstat(input logic [S_TDATA_W-1:0] item,
                                                    input logic [DOF_W-1:0] dof_in);
        logic [SSE_W-1:0]        sse;
        logic signed [WORD_W-1:0] diag;
        logic signed [WORD_W-1:0] coef;
        logic [63:0]  dof;
        logic [63:0]  mse;
        logic [127:0] prod;
        logic [63:0]  sd;
        logic [63:0]  mag;
        logic [127:0] tmag;
        logic [127:0] t;
        tstat_result_t r;
        sse  = item[SSE_W-1:0];
        diag = item[SSE_W+WORD_W-1:SSE_W];
        coef = item[SSE_W+2*WORD_W-1:SSE_W+WORD_W];
        dof  = (dof_in == 0) ? 64'd1 : 64'(dof_in);
        mse  = 64'(sse) / dof;
        sd   = 0;
        if (diag > 0 && mse != 0)
        begin
            prod = 128'(mse) * 128'(unsigned'(diag));
            if (prod[127:64] != 0)
                sd = 64'hFFFF_FFFF;
            else
                sd = int_sqrt(prod[63:0]);
            if (sd > 64'hFFFF_FFFF)
                sd = 64'hFFFF_FFFF;
        end
        mag = coef[WORD_W-1] ? 64'(-64'(signed'(coef))) : 64'(coef);
        if (128'(mag) > 128'(T_LIMIT) * 128'(sd))
            tmag = 128'(T_LIMIT) << FRACTION_BITS;
        else if (sd == 0)
            tmag = 0;
        else
            tmag = (128'(mag) << FRACTION_BITS) / 128'(sd);
        t = coef[WORD_W-1] ? -tmag : tmag;
        r.std_dev = sd[WORD_W-1:0];
        r.t_stat  = t[T_W-1:0];
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // Track the register, predict on each input transaction, check each output.
    always @(posedge clk or negedge rst_n)
    begin
        tstat_result_t exp_r;
        tstat_result_t got;
        if (!rst_n)
        begin
            dof_copy   = 1;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                dof_copy = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_results.push_back(compute_tstat(s_tdata, dof_copy));
            if (m_tvalid && m_tready)
            begin
                got.std_dev = m_tdata[WORD_W-1:0];
                got.t_stat  = m_tdata[WORD_W+T_W-1:WORD_W];
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction %h", m_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.std_dev !== exp_r.std_dev)
                    begin
                        $error("std_deviation expected %h actual %h",
                               exp_r.std_dev, got.std_dev);
                        fail_count = fail_count + 1;
                    end
                    if (got.t_stat !== exp_r.t_stat)
                    begin
                        $error("t_statistic expected %h actual %h",
                               exp_r.t_stat, got.t_stat);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import cts_pkg::*;

    localparam int PIPE_LATENCY = 88 + FRACTION_BITS_DEF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [DOF_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int fail_count;
    int pending_count;

    coefficient_t_statistic DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tstat_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Sending one transaction, after a random gap if allow_gap is set.
    task automatic send_coef(input logic [SSE_W-1:0] sse,
                             input logic [WORD_W-1:0] diag,
                             input logic [WORD_W-1:0] coef,
                             input bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 11) : 0;
        if (($urandom_range(0, 3) == 0) && allow_gap)
            gap = 0;
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {coef, diag, sse};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waiting for the pipeline to drain, then writing error_dof.
    task automatic write_dof(input logic [DOF_W-1:0] value);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 10) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SSE_W-1:0] rand_sse();
        case ($urandom_range(0, 3))
            0: return SSE_W'($urandom_range(0, 1000));
            1: return SSE_W'($urandom) << $urandom_range(0, 8);
            2: return SSE_W'({$urandom, $urandom});
            default: return SSE_W'($urandom_range(0, 65535)) << 16;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 3))
            0: return w;
            1: return w >> $urandom_range(0, 31);
            2: return -(w >> $urandom_range(0, 31));
            default: return WORD_W'($urandom_range(0, 3)) - 1;
        endcase
    endfunction

    // Receiver stalls drawn per result.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall)
                    @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        logic [DOF_W-1:0] dof_set[6];
        int waited;
        dof_set = '{12'd4095, 12'd1, 12'd0, 12'd7, 12'd200, 12'd3};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, zero and negative diagonal, zero deviation, huge variance.
        send_coef(40'd0, 32'h0001_0000, 32'd0, 1'b0);
        send_coef(40'd0, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_coef(40'd0, 32'h0001_0000, 32'h8000_0000, 1'b0);
        send_coef(40'hFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_coef(40'hFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_coef(40'hFF_FFFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0);
        send_coef(40'h1_0000, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
        send_coef(40'h1_0000, 32'd0, 32'hFFFF_0000, 1'b0);
        send_coef(40'h1_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
        send_coef(40'h4_0000, 32'h0001_0000, 32'hFFFE_0000, 1'b1);
        send_coef(40'd1, 32'd1, 32'h7FFF_FFFF, 1'b1);
        send_coef(40'd1, 32'd1, 32'd1, 1'b1);
        send_coef(40'h55_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        send_coef(40'hAA_AAAA_AAAA, 32'h2AAA_AAAA, 32'h5555_5555, 1'b1);
        send_coef(40'h64_0000, 32'h0000_0100, 32'h0000_0001, 1'b1);

        // Random phases over several settings of error_dof.
        for (int phase = 0; phase < 6; phase++)
        begin
            write_dof(dof_set[phase]);
            for (int i = 0; i < 90; i++)
                send_coef(rand_sse(), rand_word(), rand_word(),
                          (phase % 2 == 0) || (i > 45));
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending_count != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 20) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- coefficient_t_statistic.f -----
hdl/cts_pkg.sv
hdl/coefficient_t_statistic.sv
test/tstat_checker.sv
test/tb_top.sv
